### rtl/tllru_pkg.sv
// Shared types and constants for the three-level LRU cache lookup unit.
`default_nettype none
package tllru_pkg;

    localparam int unsigned LEVEL_BITS   = 2;
    localparam int unsigned LATENCY_BITS = 8;
    localparam int unsigned COUNT_BITS   = 32;

    typedef enum logic [LEVEL_BITS-1:0] {
        LEVEL_L1  = 2'd0,
        LEVEL_L2  = 2'd1,
        LEVEL_L3  = 2'd2,
        LEVEL_RAM = 2'd3
    } hit_level_t;

    localparam logic [LATENCY_BITS-1:0] LAT_L1  = 8'd4;
    localparam logic [LATENCY_BITS-1:0] LAT_L2  = 8'd12;
    localparam logic [LATENCY_BITS-1:0] LAT_L3  = 8'd40;
    localparam logic [LATENCY_BITS-1:0] LAT_RAM = 8'd200;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic match_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/three_level_lru_cache_lookup_unit.sv
// Top level: exclusive three-level LRU cache lookup as a single recency chain of cells.
//
//  channel | signals                                         | dir
//  in      | in_valid, in_ready, block_tag                   | in
//  out     | out_valid, out_ready, hit_level, access_latency,| out
//          | ram_miss_total                                  |
//
// Result valid after a parallel compare in every cell, then
// one shift step along the cell chain.
// One transaction at a time; the next is taken once the result is taken.
// Reset empties all levels and clears the miss total; no clearing pass.
// A stalled output holds the result and blocks input.
`default_nettype none
module three_level_lru_cache_lookup_unit #(
    parameter int unsigned FIRST_LEVEL_DEPTH  = 32,
    parameter int unsigned SECOND_LEVEL_DEPTH = 128,
    parameter int unsigned THIRD_LEVEL_DEPTH  = 512,
    parameter int unsigned TAG_BITS           = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] block_tag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       hit_level,
    output logic [7:0]       access_latency,
    output logic [31:0]      ram_miss_total
);
    import tllru_pkg::*;

    localparam int unsigned L2_END    = FIRST_LEVEL_DEPTH + SECOND_LEVEL_DEPTH;
    localparam int unsigned NUM_CELLS = L2_END + THIRD_LEVEL_DEPTH;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TAG_BITS-1:0]    key_reg;
    logic [COUNT_BITS-1:0]  miss_reg;
    hit_level_t             level_reg, level_next;
    logic [LATENCY_BITS-1:0] lat_reg, lat_next;
    cell_ctrl_t             ctrl;

    logic [TAG_BITS-1:0] tag_chain   [0:NUM_CELLS];
    logic                valid_chain [0:NUM_CELLS];
    logic                seen_chain  [0:NUM_CELLS];

    assign tag_chain[0]   = key_reg;
    assign valid_chain[0] = 1'b1;
    assign seen_chain[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            tllru_cell #(.TAG_BITS(TAG_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .key       (key_reg),
                .tag_in    (tag_chain[g]),
                .valid_in  (valid_chain[g]),
                .seen_in   (seen_chain[g]),
                .tag_out   (tag_chain[g+1]),
                .valid_out (valid_chain[g+1]),
                .seen_out  (seen_chain[g+1])
            );
        end
    endgenerate

    assign ctrl.match_en = (state_reg == S_MATCH);
    assign ctrl.shift_en = (state_reg == S_SHIFT);

    always_comb
    begin
        priority if (seen_chain[FIRST_LEVEL_DEPTH])
        begin
            level_next = LEVEL_L1;
            lat_next   = LAT_L1;
        end
        else if (seen_chain[L2_END])
        begin
            level_next = LEVEL_L2;
            lat_next   = LAT_L2;
        end
        else if (seen_chain[NUM_CELLS])
        begin
            level_next = LEVEL_L3;
            lat_next   = LAT_L3;
        end
        else
        begin
            level_next = LEVEL_RAM;
            lat_next   = LAT_RAM;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MATCH;
            S_MATCH: state_next = S_SHIFT;
            S_SHIFT: state_next = S_DONE;
            S_DONE:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            miss_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.shift_en && !seen_chain[NUM_CELLS] && (miss_reg != COUNT_MAX))
            begin
                miss_reg <= miss_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            key_reg <= TAG_BITS'(block_tag);
        end
        if (ctrl.shift_en)
        begin
            level_reg <= level_next;
            lat_reg   <= lat_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_DONE);
    assign hit_level      = level_reg;
    assign access_latency = lat_reg;
    assign ram_miss_total = miss_reg;

    a_shift_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |=> state_reg == S_DONE)
        else $error("shift step not followed by result");

    a_latency_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((hit_level == LEVEL_L1) == (access_latency == LAT_L1)))
        else $error("latency does not match hit level");

    a_miss_only_on_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && $past(state_reg) == S_SHIFT
            && miss_reg != $past(miss_reg)) |-> hit_level == LEVEL_RAM)
        else $error("miss total moved without a RAM miss");

endmodule
`default_nettype wire

### rtl/tllru_cell.sv
// One recency cell: holds a tag, compares it to the key, shifts from its neighbor.
`default_nettype none
module tllru_cell #(
    parameter int unsigned TAG_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tllru_pkg::cell_ctrl_t ctrl,
    input  wire logic [TAG_BITS-1:0]  key,
    input  wire logic [TAG_BITS-1:0]  tag_in,
    input  wire logic                 valid_in,
    input  wire logic                 seen_in,
    output logic      [TAG_BITS-1:0]  tag_out,
    output logic                      valid_out,
    output logic                      seen_out
);
    import tllru_pkg::*;

    logic [TAG_BITS-1:0] tag_reg;
    logic                valid_reg;
    logic                match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.match_en)
            begin
                match_reg <= valid_reg && (tag_reg == key);
            end
            if (ctrl.shift_en && !seen_in)
            begin
                valid_reg <= valid_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en && !seen_in)
        begin
            tag_reg <= tag_in;
        end
    end

    // hit cell and everything more recent take the neighbor's entry
    assign seen_out  = seen_in | match_reg;
    assign tag_out   = tag_reg;
    assign valid_out = valid_reg;

endmodule
`default_nettype wire

### sim/three_level_lru_cache_lookup_unit_tb.sv
// Testbench for the three-level exclusive LRU cache lookup unit: scoreboard with recency queues.
`timescale 1ns / 100ps
module three_level_lru_cache_lookup_unit_tb;
    import tllru_pkg::*;

    localparam int L1_DEPTH = 32;
    localparam int L2_DEPTH = 128;
    localparam int L3_DEPTH = 512;
    localparam int RANDOM_ACCESSES = 1000;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE = 720;

    typedef struct packed {
        hit_level_t  level;
        logic [7:0]  latency;
        logic [31:0] misses;
    } lookup_result_t;

    class lru_scoreboard;
        logic [15:0]    l1_tags[$];
        logic [15:0]    l2_tags[$];
        logic [15:0]    l3_tags[$];
        logic [31:0]    miss_total;
        lookup_result_t expected_q[$];
        int             errors;

        function new();
            miss_total = '0;
            errors = 0;
        endfunction

        function int locate(input logic [15:0] tags[$], input logic [15:0] tag);
            for (int i = 0; i < tags.size(); i++)
                if (tags[i] == tag)
                    return i;
            return -1;
        endfunction

        // oldest entries cascade down; L3 oldest is dropped
        function void fill_first(input logic [15:0] tag);
            logic [15:0] spill;
            l1_tags.insert(l1_tags.size(), tag);
            if (l1_tags.size() <= L1_DEPTH)
                return;
            spill = l1_tags[0];
            l1_tags.delete(0);
            l2_tags.insert(l2_tags.size(), spill);
            if (l2_tags.size() <= L2_DEPTH)
                return;
            spill = l2_tags[0];
            l2_tags.delete(0);
            l3_tags.insert(l3_tags.size(), spill);
            if (l3_tags.size() > L3_DEPTH)
                l3_tags.delete(0);
        endfunction

        function void note_access(input logic [15:0] tag);
            lookup_result_t r;
            int pos;
            pos = locate(l1_tags, tag);
            if (pos >= 0) begin
                l1_tags.delete(pos);
                l1_tags.insert(l1_tags.size(), tag);
                r.level = LEVEL_L1;
                r.latency = LAT_L1;
            end else begin
                pos = locate(l2_tags, tag);
                if (pos >= 0) begin
                    l2_tags.delete(pos);
                    r.level = LEVEL_L2;
                    r.latency = LAT_L2;
                end else begin
                    pos = locate(l3_tags, tag);
                    if (pos >= 0) begin
                        l3_tags.delete(pos);
                        r.level = LEVEL_L3;
                        r.latency = LAT_L3;
                    end else begin
                        if (miss_total != COUNT_MAX)
                            miss_total = miss_total + 1;
                        r.level = LEVEL_RAM;
                        r.latency = LAT_RAM;
                    end
                end
                fill_first(tag);
            end
            r.misses = miss_total;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(input logic [1:0] level, input logic [7:0] latency,
                                   input logic [31:0] misses);
            lookup_result_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            if (level !== e.level) begin
                $error("hit_level expected %0d actual %0d", e.level, level);
                errors++;
            end
            if (latency !== e.latency) begin
                $error("access_latency expected %0d actual %0d", e.latency, latency);
                errors++;
            end
            if (misses !== e.misses) begin
                $error("ram_miss_total expected %0d actual %0d", e.misses, misses);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] block_tag;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  hit_level;
    logic [7:0]  access_latency;
    logic [31:0] ram_miss_total;

    lru_scoreboard sb = new();
    logic [15:0]   tag_pool[POOL_SIZE];
    int            idle_cycles;
    int            cycle_count;
    int            burst_left;

    three_level_lru_cache_lookup_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .block_tag(block_tag),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit_level(hit_level),
        .access_latency(access_latency),
        .ram_miss_total(ram_miss_total)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_access(block_tag);
        if (rst_n && out_valid && out_ready)
            sb.check_result(hit_level, access_latency, ram_miss_total);
    end

    // receiver: free-running windows, some stall-heavy, some never stalling
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= cycle_count[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("three_level_lru_cache_lookup_unit: mismatch");
            $finish;
        end
    end

    // one transaction; valid stays high when the next burst item follows at once
    task automatic send(input logic [15:0] tag);
        int gap;
        in_valid <= 1'b1;
        block_tag <= tag;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [15:0] pick_tag();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return tag_pool[$urandom_range(0, 31)];
            4, 5, 6: return tag_pool[$urandom_range(0, 159)];
            7, 8: return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        block_tag = '0;
        out_ready = 1'b0;
        cycle_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = 16'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(16'h0000);
        send(16'hFFFF);
        send(16'h0000);
        send(16'hFFFF);
        send(16'h5555);
        send(16'hAAAA);
        send(16'h5555);

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            if (n == RANDOM_ACCESSES / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send(pick_tag());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("three_level_lru_cache_lookup_unit: match");
        else
            $display("three_level_lru_cache_lookup_unit: mismatch");
        $finish;
    end
endmodule
